@@ design/tsp_pkg.sv @@
// tsp_pkg: shared types and constants for the transport song position tracker
// no dependencies
package tsp_pkg;

  localparam int FRAC_BITS = 32;
  localparam int MAX_BLOCK = 4096;
  localparam int TEMPO_DIV = 60000;  // milli-bpm per bpm times seconds per minute
  localparam int DIV_STEPS = 64;
  localparam int MUL_STEPS = 13;
  localparam logic [15:0] OFF_SAT = 16'hFFFF;

  localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [0:0] REG_DRIFT_TOL   = 1'b1;

  typedef enum logic [2:0] {
    KIND_TEMPO    = 3'd0,
    KIND_NUM      = 3'd1,
    KIND_DEN      = 3'd2,
    KIND_BAR      = 3'd3,
    KIND_PLAYING  = 3'd4,
    KIND_POSITION = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAN,
    ST_DRIFT,
    ST_DIV,
    ST_EMIT,
    ST_MUL,
    ST_ADDPOS,
    ST_LOOPCHK,
    ST_WRAP,
    ST_REPORT,
    ST_RFIN,
    ST_RVAL,
    ST_ROUT
  } state_t;

endpackage

@@ design/transport_song_position_tracker.sv @@
// A host update plans its change reports, checks the drift, runs the step divide on a
// tempo change and emits its reports one at a time. A running block item multiplies the
// step by its frames (shift-add), adds it to the position and checks the loop, wrapping
// if needed; its report is dropped when the event lies behind the position and skips the
// offset divide with a zero step. A stopped block item is dropped at once. One shared
// 64-bit restoring divider (one quotient bit a cycle) does both divides. One transaction
// at a time; in_ready is high only while idle, and a stalled result holds the sequencer.
// Reset (rst, synchronous) restores all tracking state and the two registers.
module transport_song_position_tracker
  import tsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [19:0]        tempo_milli,
  input  logic signed [63:0] host_position,
  input  logic signed [63:0] host_bar_start,
  input  logic signed [63:0] host_loop_start,
  input  logic signed [63:0] host_loop_end,
  input  logic [7:0]         sig_numerator,
  input  logic [7:0]         sig_denominator,
  input  logic               host_playing,
  input  logic               host_loop_active,
  input  logic               host_loop_valid,
  input  logic [12:0]        block_frames,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         update_kind,
  output logic signed [63:0] update_value,
  output logic [15:0]        sample_offset,
  output logic               last_update
);

  // saturating signed plus unsigned
  function automatic logic signed [63:0] add_su(input logic signed [63:0] s,
                                                input logic [63:0] u);
    logic [65:0] sum;
    sum = {{2{s[63]}}, s} + {2'b00, u};
    if (!sum[65] && (sum[64:63] != 2'b00)) add_su = {1'b0, {63{1'b1}}};
    else add_su = sum[63:0];
  endfunction

  state_t state, state_next;

  // configuration
  logic [18:0] sample_rate;
  logic [31:0] drift_tolerance;

  // tracking state
  logic [19:0]        tempo_seen;
  logic [63:0]        step_per_sample;
  logic signed [63:0] song_position;
  logic signed [63:0] bar_start_seen;
  logic [7:0]         numerator_seen;
  logic [7:0]         denominator_seen;
  logic               running;
  logic signed [63:0] loop_start_pos;
  logic signed [63:0] loop_end_pos;
  logic               looping;
  logic [31:0]        last_quarter_sent;

  // latched transaction
  logic               req;
  logic [19:0]        tempo;
  logic signed [63:0] hpos;
  logic signed [63:0] hbar;
  logic signed [63:0] hls;
  logic signed [63:0] hle;
  logic [7:0]         num;
  logic [7:0]         den;
  logic               play;
  logic               lact;
  logic               lval;
  logic [12:0]        frames;

  // sequencer working registers
  logic [6:0]         mask;
  logic               tempo_chg;
  logic               stopped;
  logic signed [64:0] drift;
  logic [34:0]        dv;
  logic [63:0]        div_rem;
  logic [63:0]        div_quo;
  logic [63:0]        div_d;
  logic [6:0]         cnt;
  logic [63:0]        mcand;
  logic [63:0]        prod;
  logic signed [63:0] np;
  logic signed [63:0] ev;
  logic signed [63:0] rval;
  logic [63:0]        extra;
  logic [15:0]        roff;

  // shared divider step
  logic [64:0] rem_sh;
  logic        div_ge;
  logic [64:0] rem_sub;
  assign rem_sh  = {div_rem, div_quo[63]};
  assign rem_sub = rem_sh - {1'b0, div_d};
  assign div_ge  = rem_sh >= {1'b0, div_d};

  // scaled tolerance
  logic signed [64:0] tol_s;
  assign tol_s = (FRAC_BITS >= 32) ? (65'(drift_tolerance) << (FRAC_BITS - 32))
                                   : (65'(drift_tolerance) >> (32 - FRAC_BITS));

  // lowest pending report in the host mask
  logic [6:0] mask_low;
  assign mask_low = mask & (~mask + 7'd1);

  logic out_free;
  logic in_fire;
  assign out_free = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // handshake outputs of the sequencer
  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (!req_type) state_next = ST_PLAN;
          else if (running) state_next = ST_MUL;
        end
      end
      ST_PLAN:    state_next = ST_DRIFT;
      ST_DRIFT:   state_next = tempo_chg ? ST_DIV : ST_EMIT;
      ST_DIV: begin
        if (cnt == 7'(DIV_STEPS - 1)) state_next = req ? ST_RFIN : ST_EMIT;
      end
      ST_EMIT: begin
        if (mask == 7'd0) state_next = ST_IDLE;
      end
      ST_MUL: begin
        if (cnt == 7'(MUL_STEPS - 1)) state_next = ST_ADDPOS;
      end
      ST_ADDPOS:  state_next = ST_LOOPCHK;
      ST_LOOPCHK: begin
        if (looping && (np > loop_end_pos)) state_next = ST_WRAP;
        else if (32'(np >>> FRAC_BITS) != last_quarter_sent) state_next = ST_REPORT;
        else state_next = ST_IDLE;
      end
      ST_WRAP:    state_next = ST_REPORT;
      ST_REPORT: begin
        if (song_position > ev) state_next = ST_IDLE;
        else if (step_per_sample == 64'd0) state_next = ST_RVAL;
        else state_next = ST_DIV;
      end
      ST_RFIN:    state_next = ST_RVAL;
      ST_RVAL:    state_next = ST_ROUT;
      ST_ROUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate     <= 19'd48000;
      drift_tolerance <= 32'd429497;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate     <= cfg_data[18:0];
        REG_DRIFT_TOL:   drift_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // latch the accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req    <= req_type;
      tempo  <= tempo_milli;
      hpos   <= host_position;
      hbar   <= host_bar_start;
      hls    <= host_loop_start;
      hle    <= host_loop_end;
      num    <= sig_numerator;
      den    <= sig_denominator;
      play   <= host_playing;
      lact   <= host_loop_active;
      lval   <= host_loop_valid;
      frames <= (block_frames > 13'(MAX_BLOCK)) ? 13'(MAX_BLOCK) : block_frames;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (((state == ST_EMIT) && (mask != 7'd0) && out_free) ||
                 ((state == ST_ROUT) && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && (mask != 7'd0) && out_free) begin
      last_update   <= ((mask & ~mask_low) == 7'd0);
      sample_offset <= 16'd0;
      case (mask_low)
        7'b0000001: begin
          update_kind  <= KIND_TEMPO;
          update_value <= 64'(tempo);
        end
        7'b0000010: begin
          update_kind  <= KIND_NUM;
          update_value <= 64'(num);
        end
        7'b0000100: begin
          update_kind  <= KIND_DEN;
          update_value <= 64'(den);
        end
        7'b0001000: begin
          update_kind  <= KIND_BAR;
          update_value <= hbar;
        end
        7'b0010000: begin
          update_kind  <= KIND_PLAYING;
          update_value <= 64'(play);
        end
        default: begin
          update_kind  <= KIND_POSITION;
          update_value <= hpos;
        end
      endcase
    end else if ((state == ST_ROUT) && out_free) begin
      update_kind   <= KIND_POSITION;
      update_value  <= rval;
      sample_offset <= roff;
      last_update   <= 1'b1;
    end
  end

  // tracking state and the shared arithmetic sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      tempo_seen        <= '0;
      step_per_sample   <= '0;
      song_position     <= '0;
      bar_start_seen    <= '0;
      numerator_seen    <= '0;
      denominator_seen  <= '0;
      running           <= 1'b0;
      loop_start_pos    <= '0;
      loop_end_pos      <= '0;
      looping           <= 1'b0;
      last_quarter_sent <= '0;
      mask              <= '0;
    end else begin
      case (state)
        // compare host values with stored copies, then store them
        ST_PLAN: begin
          tempo_chg <= (tempo_seen != tempo);
          mask[0]   <= (tempo_seen != tempo);
          mask[1]   <= (numerator_seen != num);
          mask[2]   <= (denominator_seen != den);
          mask[3]   <= (bar_start_seen != hbar);
          mask[4]   <= (((tempo_seen == 20'd0) && (tempo_seen != tempo)) ? !play : running)
                       != play;
          mask[5]   <= ((((tempo_seen == 20'd0) && (tempo_seen != tempo)) ? !play : running)
                        != play) && !play;
          mask[6]   <= 1'b0;
          stopped   <= ((((tempo_seen == 20'd0) && (tempo_seen != tempo)) ? !play : running)
                        != play) && !play;
          drift     <= {song_position[63], song_position} - {hpos[63], hpos};
          dv        <= 35'(TEMPO_DIV) * 35'((sample_rate == 19'd0) ? 19'd1 : sample_rate);
          tempo_seen       <= tempo;
          numerator_seen   <= num;
          denominator_seen <= den;
          bar_start_seen   <= hbar;
          running          <= play;
          song_position    <= hpos;
          if (lact && lval) begin
            loop_start_pos <= hls;
            loop_end_pos   <= hle;
            looping        <= 1'b1;
          end else begin
            looping <= 1'b0;
          end
        end
        // drift check and divider setup for the step
        ST_DRIFT: begin
          mask[6] <= !stopped && ((drift > tol_s) || (drift < -tol_s));
          div_rem <= '0;
          div_quo <= (64'(tempo) << FRAC_BITS) + 64'(dv >> 1);
          div_d   <= 64'(dv);
          cnt     <= '0;
        end
        ST_DIV: begin
          div_quo <= {div_quo[62:0], div_ge};
          div_rem <= div_ge ? rem_sub[63:0] : rem_sh[63:0];
          cnt     <= cnt + 7'd1;
          if ((cnt == 7'(DIV_STEPS - 1)) && !req)
            step_per_sample <= {div_quo[62:0], div_ge};
        end
        ST_EMIT: begin
          if ((mask != 7'd0) && out_free) mask <= mask & ~mask_low;
        end
        // step times frames, one frame bit a cycle
        ST_MUL: begin
          if (frames[cnt[3:0]]) prod <= prod + mcand;
          mcand <= mcand << 1;
          cnt   <= cnt + 7'd1;
        end
        ST_ADDPOS: np <= add_su(song_position, prod);
        ST_LOOPCHK: begin
          if (looping && (np > loop_end_pos)) begin
            ev   <= loop_end_pos;
            rval <= loop_start_pos;
          end else begin
            ev   <= np & ~64'((65'd1 << FRAC_BITS) - 65'd1);
            rval <= np & ~64'((65'd1 << FRAC_BITS) - 65'd1);
            if (32'(np >>> FRAC_BITS) == last_quarter_sent) song_position <= np;
          end
        end
        ST_WRAP: np <= add_su(loop_start_pos, 64'(np - loop_end_pos));
        // distance to the event, then divide by the step
        ST_REPORT: begin
          extra   <= '0;
          div_rem <= '0;
          div_quo <= 64'(ev - song_position);
          div_d   <= step_per_sample;
          cnt     <= '0;
          roff    <= (ev != song_position) ? OFF_SAT : 16'd0;
          if (song_position > ev) song_position <= np;
        end
        // ceiling of the quotient and the fraction to add
        ST_RFIN: begin
          if (div_rem != 64'd0) begin
            extra <= step_per_sample - div_rem;
            roff  <= (div_quo >= 64'(OFF_SAT)) ? OFF_SAT : 16'(div_quo + 64'd1);
          end else begin
            roff  <= (div_quo > 64'(OFF_SAT)) ? OFF_SAT : 16'(div_quo);
          end
        end
        ST_RVAL: begin
          rval              <= add_su(rval, extra);
          last_quarter_sent <= 32'(rval >>> FRAC_BITS);
        end
        ST_ROUT: begin
          if (out_free) song_position <= np;
        end
        ST_IDLE: begin
          if (in_fire && req_type) begin
            prod  <= '0;
            mcand <= step_per_sample;
            cnt   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for transport_song_position_tracker
// depends on tsp_pkg and the tracker rtl; directed table then random transactions
module tb_top;
  import tsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        req_type;
    logic [19:0] tempo_milli;
    logic [63:0] host_position;
    logic [63:0] host_bar_start;
    logic [63:0] host_loop_start;
    logic [63:0] host_loop_end;
    logic [7:0]  sig_numerator;
    logic [7:0]  sig_denominator;
    logic        host_playing;
    logic        host_loop_active;
    logic        host_loop_valid;
    logic [12:0] block_frames;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [15:0] offset;
    logic        last;
  } upd_t;

  localparam longint S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S_MIN = 64'sh8000_0000_0000_0000;
  localparam longint ONE_Q = 64'sh1_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_SAMPLE_RATE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] update_kind;
  logic signed [63:0] update_value;
  logic [15:0] sample_offset;
  logic last_update;

  always #5 clk = ~clk;

  transport_song_position_tracker i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(drv.req_type), .tempo_milli(drv.tempo_milli),
    .host_position(drv.host_position), .host_bar_start(drv.host_bar_start),
    .host_loop_start(drv.host_loop_start), .host_loop_end(drv.host_loop_end),
    .sig_numerator(drv.sig_numerator), .sig_denominator(drv.sig_denominator),
    .host_playing(drv.host_playing), .host_loop_active(drv.host_loop_active),
    .host_loop_valid(drv.host_loop_valid), .block_frames(drv.block_frames),
    .out_valid(out_valid), .out_ready(out_ready), .update_kind(update_kind),
    .update_value(update_value), .sample_offset(sample_offset), .last_update(last_update)
  );

  // tracker shadow state
  logic [18:0] m_rate;
  logic [31:0] m_tol;
  logic [19:0] m_tempo;
  logic [63:0] m_step;
  longint      m_pos;
  longint      m_bar;
  logic [7:0]  m_num, m_den;
  logic        m_run;
  longint      m_lstart, m_lend;
  logic        m_loop;
  logic [31:0] m_quarter;

  upd_t pending_updates[$];
  upd_t item_updates[$];
  int   errors = 0;
  bit   no_idle = 0;
  bit   hold_rx = 0;
  int   n_rx = 0;

  function automatic longint sat_add(longint s, logic [63:0] u);
    logic [63:0] m, r;
    if (s >= 0) begin
      if (u > 64'(S_MAX) - 64'(s)) return S_MAX;
      return longint'(64'(s) + u);
    end
    m = 64'(0) - 64'(s);
    if (u >= m) begin
      r = u - m;
      return (r > 64'(S_MAX)) ? S_MAX : longint'(r);
    end
    return longint'(64'(0) - (m - u));
  endfunction

  function automatic logic [31:0] quarter_of(longint p);
    return 32'(p >>> FRAC_BITS);
  endfunction

  function automatic void push_upd(kind_t k, longint v, logic [15:0] off);
    upd_t u;
    u.kind = k; u.value = v; u.offset = off; u.last = 1'b0;
    item_updates.push_back(u);
  endfunction

  // position report at event time ev with target value tgt
  function automatic void report_crossing(longint ev, longint tgt);
    logic [63:0] d, q, r, extra;
    extra = '0;
    if (m_pos > ev) return;
    d = 64'(ev) - 64'(m_pos);
    if (m_step == 0) q = (d != 0) ? 64'd65535 : 64'd0;
    else begin
      q = d / m_step;
      r = d % m_step;
      if (r != 0) begin
        q++;
        extra = m_step - r;
      end
    end
    push_upd(KIND_POSITION, sat_add(tgt, extra), (q > 65535) ? OFF_SAT : q[15:0]);
    m_quarter = quarter_of(tgt);
  endfunction

  function automatic void predict_tracker(req_t t);
    logic [63:0] dv, err, np_u;
    longint np, fp;
    logic [12:0] fr;
    item_updates.delete();
    if (!t.req_type) begin
      if (m_tempo != t.tempo_milli) begin
        dv = 64'd60000 * ((m_rate != 0) ? 64'(m_rate) : 64'd1);
        if (m_tempo == 0) m_run = !t.host_playing;
        m_tempo = t.tempo_milli;
        push_upd(KIND_TEMPO, longint'(t.tempo_milli), 0);
        m_step = ((64'(t.tempo_milli) << FRAC_BITS) + dv / 2) / dv;
      end
      if (m_num != t.sig_numerator) begin
        m_num = t.sig_numerator;
        push_upd(KIND_NUM, longint'(t.sig_numerator), 0);
      end
      if (m_den != t.sig_denominator) begin
        m_den = t.sig_denominator;
        push_upd(KIND_DEN, longint'(t.sig_denominator), 0);
      end
      if (m_bar != longint'(t.host_bar_start)) begin
        m_bar = t.host_bar_start;
        push_upd(KIND_BAR, m_bar, 0);
      end
      if (m_run != t.host_playing) begin
        m_run = t.host_playing;
        push_upd(KIND_PLAYING, longint'(t.host_playing), 0);
        if (!t.host_playing) begin
          m_pos = t.host_position;
          push_upd(KIND_POSITION, m_pos, 0);
        end
      end
      if (t.host_loop_active && t.host_loop_valid) begin
        m_lstart = t.host_loop_start;
        m_lend = t.host_loop_end;
        m_loop = 1'b1;
      end else m_loop = 1'b0;
      err = (m_pos >= longint'(t.host_position)) ? 64'(m_pos) - t.host_position
                                                  : t.host_position - 64'(m_pos);
      m_pos = t.host_position;
      if (err > (64'(m_tol) << (FRAC_BITS - 32))) push_upd(KIND_POSITION, m_pos, 0);
    end else if (m_run) begin
      fr = (t.block_frames > MAX_BLOCK) ? 13'(MAX_BLOCK) : t.block_frames;
      np = sat_add(m_pos, m_step * 64'(fr));
      if (m_loop && np > m_lend) begin
        report_crossing(m_lend, m_lstart);
        np_u = 64'(np) - 64'(m_lend);
        np = sat_add(m_lstart, np_u);
      end else if (quarter_of(np) != m_quarter) begin
        fp = np & ~(ONE_Q - 1);
        report_crossing(fp, fp);
      end
      m_pos = np;
    end
    if (item_updates.size() > 0) item_updates[item_updates.size() - 1].last = 1'b1;
  endfunction

  task automatic reset_shadow();
    m_rate = 19'd48000; m_tol = 32'd429497; m_tempo = '0; m_step = '0; m_pos = 0;
    m_bar = 0; m_num = '0; m_den = '0; m_run = 1'b0; m_lstart = 0; m_lend = 0;
    m_loop = 1'b0; m_quarter = '0;
  endtask

  // send one transaction, predicting on acceptance; valid stays up for the next one
  task automatic send_txn(req_t t, bit idle_ok);
    while (idle_ok && !no_idle && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    drv <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tracker(t);
    foreach (item_updates[i]) pending_updates.push_back(item_updates[i]);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SAMPLE_RATE) m_rate = val[18:0];
    else m_tol = val;
    @(negedge clk);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_rx) out_ready <= 1'b0;
    else out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 18);
  end

  // result checker
  always @(posedge clk) begin
    upd_t e;
    if (!rst && out_valid && out_ready) begin
      n_rx++;
      if (pending_updates.size() == 0) begin
        $display("%0t unexpected result kind=%0d value=%0h", $realtime, update_kind,
                 update_value);
        errors++;
      end else begin
        e = pending_updates.pop_front();
        if (e.kind != update_kind || e.value != update_value ||
            e.offset != sample_offset || e.last != last_update) begin
          $display("%0t mismatch exp kind=%0d val=%0h off=%0d last=%0b", $realtime,
                   e.kind, e.value, e.offset, e.last);
          $display("%0t          act kind=%0d val=%0h off=%0d last=%0b", $realtime,
                   update_kind, update_value, sample_offset, last_update);
          errors++;
        end
      end
    end
  end

  // run limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > 2_000_000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic req_t host_upd(logic [19:0] tempo, longint pos, longint bar,
                                     logic [7:0] num, logic [7:0] den, logic play,
                                     logic lact, logic lval, longint ls, longint le);
    req_t t;
    t = '0;
    t.req_type = 1'b0; t.tempo_milli = tempo; t.host_position = pos;
    t.host_bar_start = bar; t.sig_numerator = num; t.sig_denominator = den;
    t.host_playing = play; t.host_loop_active = lact; t.host_loop_valid = lval;
    t.host_loop_start = ls; t.host_loop_end = le;
    t.block_frames = 13'($urandom);
    return t;
  endfunction

  function automatic req_t audio_blk(logic [12:0] fr);
    req_t t;
    t = '0;
    t.req_type = 1'b1; t.block_frames = fr;
    t.tempo_milli = 20'($urandom); t.host_position = {$urandom, $urandom};
    t.host_bar_start = {$urandom, $urandom}; t.host_playing = 1'($urandom);
    return t;
  endfunction

  function automatic longint rnd_pos();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return S_MAX - longint'($urandom_range(1000)) * ONE_Q;
      2: return S_MIN + longint'($urandom);
      default: return longint'($urandom_range(400)) * ONE_Q + longint'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] rnd_frames();
    case ($urandom_range(9))
      0: return 13'($urandom);
      1: return 13'(4096 + $urandom_range(4095));
      2: return 13'd0;
      default: return 13'($urandom_range(1, 1024));
    endcase
  endfunction

  // directed table: row plus an optional typed first result
  typedef struct {
    req_t t;
    bit   has_exp;
    upd_t first;
  } row_t;

  row_t table_rows[$];

  task automatic add_row(req_t t, bit has_exp = 0, upd_t first = '0);
    row_t r;
    r.t = t; r.has_exp = has_exp; r.first = first;
    table_rows.push_back(r);
  endtask

  initial begin
    int i;
    req_t t;
    longint pos;
    reset_shadow();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    add_row(audio_blk(13'd100));                                     // stopped: ignored
    add_row(host_upd(20'd120000, 0, 0, 8'd4, 8'd4, 1'b1, 0, 0, 0, 0), 1,
            '{KIND_TEMPO, 64'd120000, 16'd0, 1'b0});                 // first tempo
    add_row(audio_blk(13'd4096));
    add_row(audio_blk(13'd8191));                                    // long block
    add_row(audio_blk(13'd0));
    add_row(host_upd(20'd999999, 5 * ONE_Q, 3 * ONE_Q, 8'd255, 8'd255, 1'b1, 1, 1,
                     4 * ONE_Q, 6 * ONE_Q));                         // loop on
    for (i = 0; i < 6; i++) add_row(audio_blk(13'd4096));            // wrap at loop end
    add_row(host_upd(20'd1, S_MAX, S_MIN, 8'd0, 8'd0, 1'b1, 1, 0, 0, 0));
    add_row(audio_blk(13'd4096));                                    // step of one LSB
    add_row(host_upd(20'd999999, S_MAX - ONE_Q, S_MAX, 8'd1, 8'd2, 1'b1, 0, 1, 0, 0));
    add_row(audio_blk(13'd4096));                                    // saturation
    add_row(host_upd(20'd999999, S_MIN, 0, 8'd1, 8'd2, 1'b1, 1, 1, S_MIN, S_MIN));
    add_row(audio_blk(13'd50));                                      // event at the position
    add_row(host_upd(20'd60000, -ONE_Q, 0, 8'd3, 8'd8, 1'b0, 0, 0, 0, 0), 1,
            '{KIND_TEMPO, 64'd60000, 16'd0, 1'b0});                  // stop
    add_row(host_upd(20'd60000, -ONE_Q + 1, 0, 8'd3, 8'd8, 1'b0, 0, 0, 0, 0));
    add_row(host_upd(20'd60000, ONE_Q, 0, 8'd3, 8'd8, 1'b1, 0, 0, 0, 0), 1,
            '{KIND_PLAYING, 64'd1, 16'd0, 1'b0});

    foreach (table_rows[r]) begin
      send_txn(table_rows[r].t, 1'b1);
      if (table_rows[r].has_exp) begin
        if (item_updates.size() == 0 || item_updates[0] != table_rows[r].first) begin
          $display("%0t table row %0d exp first %0h", $realtime, r, table_rows[r].first);
          errors++;
        end
      end
    end
    wait_drained();

    // random phases over register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(REG_SAMPLE_RATE, 32'd8000); write_reg(REG_DRIFT_TOL, 32'd0); end
        1: begin write_reg(REG_SAMPLE_RATE, 32'd384000);
                 write_reg(REG_DRIFT_TOL, 32'hFFFF_FFFF); end
        2: begin write_reg(REG_SAMPLE_RATE, 32'h7FFFF); write_reg(REG_DRIFT_TOL, $urandom); end
        3: begin write_reg(REG_SAMPLE_RATE, 32'd0); write_reg(REG_DRIFT_TOL, 32'd429497); end
        default: begin
          write_reg(REG_SAMPLE_RATE, $urandom_range(8000, 384000));
          write_reg(REG_DRIFT_TOL, $urandom_range(0, 5_000_000));
        end
      endcase
      no_idle = (ph == 2);
      for (i = 0; i < 80; i++) begin
        if (ph == 1 && i == 20) begin
          fork
            begin hold_rx = 1; repeat (300) @(negedge clk); hold_rx = 0; end
          join_none
        end
        if ($urandom_range(99) < 25) begin
          pos = rnd_pos();
          t = host_upd(($urandom_range(3) == 0) ? 20'($urandom_range(1, 999999))
                                                : 20'($urandom_range(60000, 200000)),
                       ($urandom_range(3) == 0) ? pos : m_pos + longint'($urandom_range(1000)),
                       ($urandom_range(2) == 0) ? rnd_pos() : m_bar,
                       ($urandom_range(3) == 0) ? 8'($urandom) : m_num,
                       ($urandom_range(3) == 0) ? 8'($urandom) : m_den,
                       ($urandom_range(9) != 0),
                       1'($urandom), ($urandom_range(3) != 0), 0, 0);
          t.host_loop_start = ($urandom_range(3) == 0) ? rnd_pos()
                              : t.host_position - longint'($urandom_range(4)) * ONE_Q;
          t.host_loop_end = ($urandom_range(3) == 0) ? rnd_pos()
                            : t.host_position + longint'($urandom_range(0, 8)) * ONE_Q
                              + longint'($urandom);
        end else t = audio_blk(rnd_frames());
        send_txn(t, 1'b1);
      end
      wait_drained();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
